[rtl/core/akf_pkg.sv]
// akf_pkg: shared types, reset constants and helpers for the angle kalman filter core
// no dependencies
`timescale 1ns / 1ps

package akf_pkg;

   localparam int DataWidth = 32;
   localparam int CfgWidth  = 31;
   localparam int CsrIdxWidth = 2;

   localparam logic [CfgWidth-1:0] QaReset = 31'd66;
   localparam logic [CfgWidth-1:0] QbReset = 31'd197;
   localparam logic [CfgWidth-1:0] RnReset = 31'd32768;
   localparam logic [CfgWidth-1:0] DtReset = 31'd328;
   localparam logic signed [DataWidth-1:0] QOne = 32'sd65536;

   localparam logic [CsrIdxWidth-1:0] RegQa = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegQb = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegRn = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegDt = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_DONE,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/core/angle_kalman_filter_core.sv]
// angle_kalman_filter_core: two-state angle / gyro-bias kalman filter, signed q16.16
// depends on akf_pkg
`timescale 1ns / 1ps
// Usage:
// req_ beats carry one sample: tdata[31:0] accel_angle, tdata[63:32] gyro_rate.
// rsp_ beats carry angle_estimate, rate_estimate and bias_estimate in tdata.
// csr_ writes set the noise terms and time step; write only while idle.
// One sample runs from its accept edge to rsp_tvalid through eleven steps of a
// shared 32x32 multiplier (product state then saturating add state), one setup state
// and two 48-step restoring divisions on one shared divider, one bit per cycle plus
// a finishing state each. With a non-positive innovation variance the divisions are
// skipped and the remaining multiplier steps follow directly.
// req_tready is high only while no sample is in work, so a new sample is not taken
// until the previous one is through. A finished sample waits in its last step while
// an earlier result is still held, so a stalled receiver blocks the sample after next.
// Reset (synchronous, active high) restores register defaults, zero angle and
// bias, and identity covariance.
module angle_kalman_filter_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*akf_pkg::DataWidth-1:0] req_tdata,  // accel_angle, gyro_rate
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [3*akf_pkg::DataWidth-1:0] rsp_tdata,  // angle_estimate, rate_estimate, bias_estimate
   input  logic                    csr_wr_en,
   input  logic [akf_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [akf_pkg::CfgWidth-1:0]    csr_wdata
);

   typedef logic signed [31:0] s32_type;

   logic [akf_pkg::CfgWidth-1:0] qa_ff, qb_ff, rn_ff, dt_ff;
   s32_type ang_ff, ang_in, bias_ff, bias_in;
   s32_type p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   s32_type meas_ff, meas_in, gyro_ff, gyro_in;
   s32_type r_ff, r_in, d0_ff, d0_in, d1_ff, d1_in, e_ff, e_in;
   s32_type ga_ff, ga_in, gb_ff, gb_in, sa_ff, sa_in, sb_ff, sb_in, var_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [3:0] step_ff, step_in;
   akf_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3*akf_pkg::DataWidth-1:0] rsp_data_ff, rsp_data_in;
   // divider
   logic [47:0] dq_ff, dq_in;
   logic [48:0] drem_ff, drem_in;
   logic [31:0] dden_ff, dden_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic        dneg_ff, dneg_in, dsel_ff, dsel_in;

   // shared multiplier operand select
   s32_type ma, mb, acc;
   logic sub;
   s32_type dts;
   s32_type mres;
   logic signed [63:0] fl;
   assign dts = s32_type'({1'b0, dt_ff});
   always_comb begin
      ma = r_ff; mb = dts; acc = ang_ff; sub = 1'b0;
      case (step_ff)
         4'd0: begin ma = r_ff;  mb = dts; acc = ang_ff; end
         4'd1: begin ma = d0_ff; mb = dts; acc = p00_ff; end
         4'd2: begin ma = d1_ff; mb = dts; acc = p01_ff; end
         4'd3: begin ma = d1_ff; mb = dts; acc = p10_ff; end
         4'd4: begin ma = s32_type'({1'b0, qb_ff}); mb = dts; acc = p11_ff; end
         4'd5: begin ma = ga_ff; mb = sa_ff; acc = p00_ff; sub = 1'b1; end
         4'd6: begin ma = ga_ff; mb = sb_ff; acc = p01_ff; sub = 1'b1; end
         4'd7: begin ma = gb_ff; mb = sa_ff; acc = p10_ff; sub = 1'b1; end
         4'd8: begin ma = gb_ff; mb = sb_ff; acc = p11_ff; sub = 1'b1; end
         4'd9: begin ma = ga_ff; mb = e_ff;  acc = ang_ff; end
         default: begin ma = gb_ff; mb = e_ff; acc = bias_ff; end
      endcase
      fl = prod_ff >>> 16;
      mres = akf_pkg::sat32(66'(fl));
   end

   s32_type accres;
   assign accres = sub ? akf_pkg::sat32(66'(acc) - 66'(mres))
                       : akf_pkg::sat32(66'(acc) + 66'(mres));

   // divider trial subtraction and signed result
   logic [48:0] dtrial;
   logic [47:0] dmag;
   assign dtrial = {drem_ff[47:0], dq_ff[47]} - {17'd0, dden_ff};
   s32_type dres;
   always_comb begin
      dmag = dq_ff;
      if (dneg_ff) dres = akf_pkg::sat32(-$signed({18'd0, dmag}));
      else dres = akf_pkg::sat32($signed({18'd0, dmag}));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         akf_pkg::ST_IDLE: if (req_tvalid && req_tready) state_in = akf_pkg::ST_MUL;
         akf_pkg::ST_MUL: state_in = akf_pkg::ST_ACC;
         akf_pkg::ST_ACC: begin
            if (step_ff == 4'd4) state_in = akf_pkg::ST_DIV_SETUP;
            else if (step_ff == 4'd10) state_in = akf_pkg::ST_OUT;
            else state_in = akf_pkg::ST_MUL;
         end
         akf_pkg::ST_DIV_SETUP: begin
            if (var_in <= 0) state_in = akf_pkg::ST_MUL;
            else state_in = akf_pkg::ST_DIV;
         end
         akf_pkg::ST_DIV: if (dcnt_ff == 6'd47) state_in = akf_pkg::ST_DIV_DONE;
         akf_pkg::ST_DIV_DONE: begin
            if (dsel_ff) state_in = akf_pkg::ST_MUL;
            else state_in = akf_pkg::ST_DIV;
         end
         akf_pkg::ST_OUT: if (!rsp_valid_ff || rsp_tready) state_in = akf_pkg::ST_IDLE;
         default: state_in = akf_pkg::ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == akf_pkg::ST_IDLE);

   // datapath
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      meas_in = meas_ff; gyro_in = gyro_ff; r_in = r_ff; d0_in = d0_ff; d1_in = d1_ff;
      e_in = e_ff; ga_in = ga_ff; gb_in = gb_ff; sa_in = sa_ff; sb_in = sb_ff;
      var_in = akf_pkg::sat32(66'($signed({1'b0, rn_ff})) + 66'(p00_ff));
      prod_in = prod_ff; step_in = step_ff;
      dq_in = dq_ff; drem_in = drem_ff; dden_in = dden_ff; dcnt_in = dcnt_ff;
      dneg_in = dneg_ff; dsel_in = dsel_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         akf_pkg::ST_IDLE: begin
            meas_in = s32_type'(req_tdata[31:0]);
            gyro_in = s32_type'(req_tdata[63:32]);
            r_in = akf_pkg::sat32(66'(s32_type'(req_tdata[63:32])) - 66'(bias_ff));
            d0_in = akf_pkg::sat32(66'($signed({1'b0, qa_ff})) - 66'(p01_ff) - 66'(p10_ff));
            d1_in = akf_pkg::sat32(-66'(p11_ff));
            step_in = 4'd0;
         end
         akf_pkg::ST_MUL: prod_in = 64'(ma) * 64'(mb);
         akf_pkg::ST_ACC: begin
            case (step_ff)
               4'd0: ang_in = accres;
               4'd1: p00_in = accres;
               4'd2: p01_in = accres;
               4'd3: p10_in = accres;
               4'd4: p11_in = accres;
               4'd5: p00_in = accres;
               4'd6: p01_in = accres;
               4'd7: p10_in = accres;
               4'd8: p11_in = accres;
               4'd9: ang_in = accres;
               default: begin
                  bias_in = accres;
                  r_in = akf_pkg::sat32(66'(gyro_ff) - 66'(accres));
               end
            endcase
            step_in = step_ff + 4'd1;
         end
         akf_pkg::ST_DIV_SETUP: begin
            e_in = akf_pkg::sat32(66'(meas_ff) - 66'(ang_ff));
            sa_in = p00_ff; sb_in = p01_ff;
            ga_in = '0; gb_in = '0;
            dden_in = 32'(var_in);
            dsel_in = 1'b0;
            dq_in = {p00_ff[31] ? 32'(-p00_ff) : 32'(p00_ff), 16'd0};
            dneg_in = p00_ff[31];
            drem_in = '0; dcnt_in = '0;
         end
         akf_pkg::ST_DIV: begin
            if (!dtrial[48]) drem_in = dtrial;
            else drem_in = {drem_ff[47:0], dq_ff[47]};
            dq_in = {dq_ff[46:0], ~dtrial[48]};
            dcnt_in = dcnt_ff + 6'd1;
         end
         akf_pkg::ST_DIV_DONE: begin
            if (dsel_ff) gb_in = dres;
            else begin
               ga_in = dres;
               dsel_in = 1'b1;
               dq_in = {p10_ff[31] ? 32'(-p10_ff) : 32'(p10_ff), 16'd0};
               dneg_in = p10_ff[31];
               drem_in = '0; dcnt_in = '0;
            end
         end
         akf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {bias_ff, r_ff, ang_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= akf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         qa_ff <= akf_pkg::QaReset; qb_ff <= akf_pkg::QbReset;
         rn_ff <= akf_pkg::RnReset; dt_ff <= akf_pkg::DtReset;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= akf_pkg::QOne; p01_ff <= '0; p10_ff <= '0; p11_ff <= akf_pkg::QOne;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               akf_pkg::RegQa: qa_ff <= csr_wdata;
               akf_pkg::RegQb: qb_ff <= csr_wdata;
               akf_pkg::RegRn: rn_ff <= csr_wdata;
               akf_pkg::RegDt: dt_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in; gyro_ff <= gyro_in; r_ff <= r_in; d0_ff <= d0_in; d1_ff <= d1_in;
      e_ff <= e_in; ga_ff <= ga_in; gb_ff <= gb_in; sa_ff <= sa_in; sb_ff <= sb_in;
      prod_ff <= prod_in; step_ff <= step_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dden_ff <= dden_in; dcnt_ff <= dcnt_in;
      dneg_ff <= dneg_in; dsel_ff <= dsel_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

[tb/testbench.sv]
// testbench for angle_kalman_filter_core: streams imu samples, predicts the filter in q16.16
// and checks every result beat against a scoreboard; depends on akf_pkg and the core
`timescale 1ns / 1ps

class kalman_scoreboard;
   logic [30:0] qa, qb, rn, dt;
   logic signed [31:0] ang, bias;
   logic signed [31:0] p00, p01, p10, p11;
   logic [95:0] expected_q[$];
   int errors;

   function new();
      errors = 0;
      reset_state();
   endfunction

   function void reset_state();
      qa = akf_pkg::QaReset; qb = akf_pkg::QbReset;
      rn = akf_pkg::RnReset; dt = akf_pkg::DtReset;
      ang = 0; bias = 0;
      p00 = 65536; p01 = 0; p10 = 0; p11 = 65536;
   endfunction

   function void write_reg(logic [1:0] idx, logic [30:0] v);
      case (idx)
         akf_pkg::RegQa: qa = v;
         akf_pkg::RegQb: qb = v;
         akf_pkg::RegRn: rn = v;
         akf_pkg::RegDt: dt = v;
         default: ;
      endcase
   endfunction

   function logic signed [31:0] clip(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b);
      return clip(p >>> 16);
   endfunction

   function logic signed [31:0] qdiv(logic signed [31:0] n, logic signed [31:0] d);
      logic signed [65:0] q;
      if (d <= 0) return 0;
      q = (66'(n) * 66'sd65536) / 66'(d);
      return clip(q);
   endfunction

   function void note_sample(logic signed [31:0] meas, logic signed [31:0] gyro);
      logic signed [31:0] r, d0, d1, e, v, ga, gb, sa, sb, sdt;
      sdt = {1'b0, dt};
      r = clip(66'(gyro) - 66'(bias));
      ang = clip(66'(ang) + 66'(qmul(r, sdt)));
      d0 = clip(66'($signed({1'b0, qa})) - 66'(p01) - 66'(p10));
      d1 = clip(-66'(p11));
      p00 = clip(66'(p00) + 66'(qmul(d0, sdt)));
      p01 = clip(66'(p01) + 66'(qmul(d1, sdt)));
      p10 = clip(66'(p10) + 66'(qmul(d1, sdt)));
      p11 = clip(66'(p11) + 66'(qmul($signed({1'b0, qb}), sdt)));
      e = clip(66'(meas) - 66'(ang));
      v = clip(66'($signed({1'b0, rn})) + 66'(p00));
      ga = qdiv(p00, v);
      gb = qdiv(p10, v);
      sa = p00; sb = p01;
      p00 = clip(66'(p00) - 66'(qmul(ga, sa)));
      p01 = clip(66'(p01) - 66'(qmul(ga, sb)));
      p10 = clip(66'(p10) - 66'(qmul(gb, sa)));
      p11 = clip(66'(p11) - 66'(qmul(gb, sb)));
      ang = clip(66'(ang) + 66'(qmul(ga, e)));
      bias = clip(66'(bias) + 66'(qmul(gb, e)));
      r = clip(66'(gyro) - 66'(bias));
      expected_q.push_back({bias, r, ang});
   endfunction

   function void check_result(logic [95:0] got);
      logic [95:0] want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result beat, actual %h", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      for (int f = 0; f < 3; f++)
         if (want[32*f +: 32] !== got[32*f +: 32]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     want[32*f +: 32], got[32*f +: 32]);
            errors++;
         end
   endfunction
endclass

module testbench;
   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [63:0] req_tdata = 0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = 0;
   logic [30:0] csr_wdata = 0;
   int send_idle = 0, recv_idle = 0, stall_cycles = 0;
   kalman_scoreboard sb = new();

   always #2 clock = ~clock;

   angle_kalman_filter_core DUT (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock)
      if (stall_cycles > 20000) begin
         $display("** angle_kalman_filter_core: FAILED **");
         $finish;
      end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   task automatic send_sample(logic [31:0] meas, logic [31:0] gyro);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {gyro, meas};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(meas, gyro);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [30:0] v);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_sample(32'h0001_0000, 32'h0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h0, 32'h8000_0000);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001);
      drain();
      // extreme registers and zero measurement noise
      write_csr(akf_pkg::RegQa, 31'h7FFF_FFFF);
      write_csr(akf_pkg::RegQb, 31'h7FFF_FFFF);
      write_csr(akf_pkg::RegRn, 31'h0);
      write_csr(akf_pkg::RegDt, 31'h7FFF_FFFF);
      csr_wr_en <= 0;
      for (int i = 0; i < 8; i++) send_sample(pick_value(), pick_value());
      drain();
      write_csr(akf_pkg::RegQa, 31'h0);
      write_csr(akf_pkg::RegQb, 31'h0);
      write_csr(akf_pkg::RegRn, 31'h1);
      write_csr(akf_pkg::RegDt, 31'h1);
      csr_wr_en <= 0;
      for (int i = 0; i < 6; i++) send_sample(pick_value(), pick_value());
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 32 : (ph == 1) ? 68 : 0;
         recv_idle = (ph == 0) ? 68 : (ph == 1) ? 32 : 0;
         write_csr(akf_pkg::RegQa, 31'($urandom_range(400)));
         write_csr(akf_pkg::RegQb, 31'($urandom_range(800)));
         write_csr(akf_pkg::RegRn, 31'($urandom_range(1, 100000)));
         write_csr(akf_pkg::RegDt, 31'($urandom_range(1, 4000)));
         csr_wr_en <= 0;
         for (int i = 0; i < 150; i++) send_sample(pick_value(), pick_value());
         drain();
      end
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("** angle_kalman_filter_core: PASSED **");
      else
         $display("** angle_kalman_filter_core: FAILED **");
      $finish;
   end
endmodule
